// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
// Needs signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_RUN(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/lsa_pkg.sv =====
// Types and codes for the lidar sector avoidance block.
// No dependencies; used by the RTL, the checker and the testbench.
package lsa_pkg;

   typedef enum logic [2:0] {
      CSR_MIN_VALID,
      CSR_MAX_VALID,
      CSR_SCAN_MAX,
      CSR_CLOSE,
      CSR_DANGER,
      CSR_RIGHT_END,
      CSR_FRONT_END
   } lsa_csr_type;

   typedef enum logic [1:0] {
      SEC_RIGHT,
      SEC_FRONT,
      SEC_LEFT
   } lsa_sector_type;

   typedef enum logic [1:0] {
      DRIVE_FORWARD,
      DRIVE_STOP,
      DRIVE_REVERSE
   } lsa_drive_type;

   localparam logic signed [1:0] TURN_RIGHT = -2'sd1;
   localparam logic signed [1:0] TURN_NONE  = 2'sd0;
   localparam logic signed [1:0] TURN_LEFT  = 2'sd1;

   localparam logic [15:0] RST_MIN_VALID = 16'd20;
   localparam logic [15:0] RST_MAX_VALID = 16'd5500;
   localparam logic [15:0] RST_SCAN_MAX  = 16'd65535;
   localparam logic [15:0] RST_CLOSE     = 16'd800;
   localparam logic [15:0] RST_DANGER    = 16'd600;
   localparam logic [9:0]  RST_RIGHT_END = 10'd242;
   localparam logic [9:0]  RST_FRONT_END = 10'd482;

   localparam logic [15:0] SECTOR_MIN_INIT = 16'hFFFF;

   typedef struct packed {
      logic [15:0] scan_max;
      logic [15:0] close;
      logic [15:0] danger;
   } lsa_thresh_type;

endpackage

// ===== hw/rtl/lsa_req_if.sv =====
// Sample channel: valid/ready handshake carrying one range word.
// No dependencies.
interface lsa_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_mm;
   logic        not_a_number;
   logic        last_sample;

   modport source (output valid, range_mm, not_a_number, last_sample, input ready);
   modport sink   (input valid, range_mm, not_a_number, last_sample, output ready);
endinterface

// ===== hw/rtl/lsa_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one decision word.
// No dependencies.
interface lsa_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         drive_mode;
   logic signed [1:0]  turn_dir;
   logic [15:0]        front_min_mm;
   logic [15:0]        left_min_mm;
   logic [15:0]        right_min_mm;

   modport source (output valid, drive_mode, turn_dir, front_min_mm, left_min_mm,
                   right_min_mm, input ready);
   modport sink   (input valid, drive_mode, turn_dir, front_min_mm, left_min_mm,
                   right_min_mm, output ready);
endinterface

// ===== hw/rtl/lsa_decide.sv =====
// Two-stage decision pipe: clamps minima, forms average thresholds, picks mode and turn.
// Depends on lsa_pkg and lsa_rsp_if.
module lsa_decide #(
   parameter int CNT_W = 11,
   localparam int TOT_W = 16 + CNT_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lsa_pkg::lsa_thresh_type thresh,
   input  logic                    snap_valid,
   output logic                    snap_ready,
   input  logic [TOT_W-1:0]        total_l,
   input  logic [TOT_W-1:0]        total_r,
   input  logic [CNT_W-1:0]        cnt_l,
   input  logic [CNT_W-1:0]        cnt_r,
   input  logic [15:0]             min_f,
   input  logic [15:0]             min_l,
   input  logic [15:0]             min_r,
   lsa_rsp_if.source               rsp
);

   logic             prod_valid_ff, prod_valid_in;
   logic [15:0]      fmin_ff, lmin_ff, rmin_ff;
   logic [TOT_W-1:0] tot_l_ff, tot_r_ff, prod_l_ff, prod_r_ff;
   logic [15:0]      fmin_in, lmin_in, rmin_in;
   logic [TOT_W-1:0] prod_l_in, prod_r_in;
   logic [CNT_W-1:0] cnt1_l, cnt1_r;
   logic             prod_ready, out_ready;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        mode_ff, mode_in;
   logic signed [1:0] turn_ff, turn_in;
   logic [15:0]       rsp_f_ff, rsp_l_ff, rsp_r_ff;
   logic              below_l, below_r;

   assign out_ready  = !rsp_valid_ff || rsp.ready;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign snap_ready = prod_ready;

   always_comb begin
      fmin_in   = (min_f < thresh.scan_max) ? min_f : thresh.scan_max;
      lmin_in   = (min_l < thresh.scan_max) ? min_l : thresh.scan_max;
      rmin_in   = (min_r < thresh.scan_max) ? min_r : thresh.scan_max;
      cnt1_l    = (cnt_l == '0) ? CNT_W'(1) : cnt_l;
      cnt1_r    = (cnt_r == '0) ? CNT_W'(1) : cnt_r;
      prod_l_in = TOT_W'(thresh.close) * TOT_W'(cnt1_l);
      prod_r_in = TOT_W'(thresh.close) * TOT_W'(cnt1_r);
      prod_valid_in = prod_ready ? snap_valid : prod_valid_ff;
   end

   always_comb begin
      below_l = tot_l_ff < prod_l_ff;
      below_r = tot_r_ff < prod_r_ff;
      turn_in = lsa_pkg::TURN_NONE;
      priority if (fmin_ff < thresh.danger) begin
         mode_in = lsa_pkg::DRIVE_REVERSE;
      end else if (fmin_ff < thresh.close) begin
         mode_in = lsa_pkg::DRIVE_STOP;
      end else begin
         mode_in = lsa_pkg::DRIVE_FORWARD;
      end
      if (mode_in != lsa_pkg::DRIVE_FORWARD) begin
         turn_in = (rmin_ff > lmin_ff) ? lsa_pkg::TURN_RIGHT : lsa_pkg::TURN_LEFT;
      end else begin
         unique case ({below_l, below_r})
            2'b10:   turn_in = lsa_pkg::TURN_RIGHT;
            2'b01:   turn_in = lsa_pkg::TURN_LEFT;
            default: turn_in = lsa_pkg::TURN_NONE;
         endcase
      end
      rsp_valid_in = out_ready ? prod_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (prod_ready && snap_valid) begin
         fmin_ff   <= fmin_in;
         lmin_ff   <= lmin_in;
         rmin_ff   <= rmin_in;
         tot_l_ff  <= total_l;
         tot_r_ff  <= total_r;
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
      end
      if (out_ready && prod_valid_ff) begin
         mode_ff  <= mode_in;
         turn_ff  <= turn_in;
         rsp_f_ff <= fmin_ff;
         rsp_l_ff <= lmin_ff;
         rsp_r_ff <= rmin_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.drive_mode   = mode_ff;
   assign rsp.turn_dir     = turn_ff;
   assign rsp.front_min_mm = rsp_f_ff;
   assign rsp.left_min_mm  = rsp_l_ff;
   assign rsp.right_min_mm = rsp_r_ff;

endmodule

// ===== hw/rtl/lidar_sector_avoidance.sv =====
// Lidar sector avoidance: accumulates right/front/left sector totals, counts and minima.
// Takes one sample word per cycle unless stalled; the result word for a scan is registered
// through the snapshot, one multiply stage and one decision stage after its last sample.
// Throughput one sample per cycle, stalls only while a result backs up the decision pipe.
// Synchronous active-high reset restores the register defaults and clears the scan state.
// Depends on lsa_pkg, lsa_req_if, lsa_rsp_if and lsa_decide.
module lidar_sector_avoidance #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   lsa_req_if.sink     req_word,
   lsa_rsp_if.source   rsp_word,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IW    = $clog2(MAX_SAMPLES + 1);
   localparam int CW    = (IW > 10) ? IW : 10;
   localparam int TOT_W = 16 + IW;

   logic [15:0] min_valid_ff, max_valid_ff, scan_max_ff, close_ff, danger_ff;
   logic [9:0]  right_end_ff, front_end_ff;

   logic [IW-1:0]    idx_ff, idx_in;
   logic [TOT_W-1:0] tot_ff [3];
   logic [TOT_W-1:0] tot_in [3];
   logic [TOT_W-1:0] tot_nx [3];
   logic [IW-1:0]    cnt_ff [3];
   logic [IW-1:0]    cnt_in [3];
   logic [IW-1:0]    cnt_nx [3];
   logic [15:0]      min_ff [3];
   logic [15:0]      min_in [3];
   logic [15:0]      min_nx [3];

   logic             snap_valid_ff, snap_valid_in, snap_ready;
   logic [TOT_W-1:0] snap_tot_l_ff, snap_tot_r_ff;
   logic [IW-1:0]    snap_cnt_l_ff, snap_cnt_r_ff;
   logic [15:0]      snap_min_f_ff, snap_min_l_ff, snap_min_r_ff;

   logic                    accept, in_scan, take;
   lsa_pkg::lsa_sector_type sel;
   lsa_pkg::lsa_thresh_type thresh;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_valid_ff <= lsa_pkg::RST_MIN_VALID;
         max_valid_ff <= lsa_pkg::RST_MAX_VALID;
         scan_max_ff  <= lsa_pkg::RST_SCAN_MAX;
         close_ff     <= lsa_pkg::RST_CLOSE;
         danger_ff    <= lsa_pkg::RST_DANGER;
         right_end_ff <= lsa_pkg::RST_RIGHT_END;
         front_end_ff <= lsa_pkg::RST_FRONT_END;
      end else if (csr_we) begin
         unique case (lsa_pkg::lsa_csr_type'(csr_index))
            lsa_pkg::CSR_MIN_VALID: min_valid_ff <= csr_wdata;
            lsa_pkg::CSR_MAX_VALID: max_valid_ff <= csr_wdata;
            lsa_pkg::CSR_SCAN_MAX:  scan_max_ff  <= csr_wdata;
            lsa_pkg::CSR_CLOSE:     close_ff     <= csr_wdata;
            lsa_pkg::CSR_DANGER:    danger_ff    <= csr_wdata;
            lsa_pkg::CSR_RIGHT_END: right_end_ff <= csr_wdata[9:0];
            lsa_pkg::CSR_FRONT_END: front_end_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   assign req_word.ready = !snap_valid_ff || snap_ready;
   assign accept  = req_word.valid && req_word.ready;
   assign in_scan = idx_ff < IW'(MAX_SAMPLES);
   assign take    = in_scan && !req_word.not_a_number
                 && (req_word.range_mm >= min_valid_ff)
                 && (req_word.range_mm <= max_valid_ff);

   always_comb begin
      priority if (CW'(idx_ff) < CW'(right_end_ff)) begin
         sel = lsa_pkg::SEC_RIGHT;
      end else if (CW'(idx_ff) < CW'(front_end_ff)) begin
         sel = lsa_pkg::SEC_FRONT;
      end else begin
         sel = lsa_pkg::SEC_LEFT;
      end
   end

   always_comb begin
      tot_nx = tot_ff;
      cnt_nx = cnt_ff;
      min_nx = min_ff;
      if (take) begin
         tot_nx[sel] = tot_ff[sel] + TOT_W'(req_word.range_mm);
         cnt_nx[sel] = cnt_ff[sel] + IW'(1);
         if (req_word.range_mm < min_ff[sel]) begin
            min_nx[sel] = req_word.range_mm;
         end
      end
      idx_in = idx_ff;
      tot_in = tot_ff;
      cnt_in = cnt_ff;
      min_in = min_ff;
      if (accept) begin
         if (req_word.last_sample) begin
            idx_in = '0;
            for (int s = 0; s < 3; s++) begin
               tot_in[s] = '0;
               cnt_in[s] = '0;
               min_in[s] = lsa_pkg::SECTOR_MIN_INIT;
            end
         end else begin
            idx_in = in_scan ? idx_ff + IW'(1) : idx_ff;
            tot_in = tot_nx;
            cnt_in = cnt_nx;
            min_in = min_nx;
         end
      end
      if (accept && req_word.last_sample) begin
         snap_valid_in = 1'b1;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         snap_valid_ff <= 1'b0;
         for (int s = 0; s < 3; s++) begin
            tot_ff[s] <= '0;
            cnt_ff[s] <= '0;
            min_ff[s] <= lsa_pkg::SECTOR_MIN_INIT;
         end
      end else begin
         idx_ff        <= idx_in;
         snap_valid_ff <= snap_valid_in;
         tot_ff        <= tot_in;
         cnt_ff        <= cnt_in;
         min_ff        <= min_in;
      end
      if (accept && req_word.last_sample) begin
         snap_tot_l_ff <= tot_nx[lsa_pkg::SEC_LEFT];
         snap_tot_r_ff <= tot_nx[lsa_pkg::SEC_RIGHT];
         snap_cnt_l_ff <= cnt_nx[lsa_pkg::SEC_LEFT];
         snap_cnt_r_ff <= cnt_nx[lsa_pkg::SEC_RIGHT];
         snap_min_f_ff <= min_nx[lsa_pkg::SEC_FRONT];
         snap_min_l_ff <= min_nx[lsa_pkg::SEC_LEFT];
         snap_min_r_ff <= min_nx[lsa_pkg::SEC_RIGHT];
      end
   end

   assign thresh.scan_max = scan_max_ff;
   assign thresh.close    = close_ff;
   assign thresh.danger   = danger_ff;

   lsa_decide #(
      .CNT_W (IW)
   ) u_decide (
      .clock      (clock),
      .reset      (reset),
      .thresh     (thresh),
      .snap_valid (snap_valid_ff),
      .snap_ready (snap_ready),
      .total_l    (snap_tot_l_ff),
      .total_r    (snap_tot_r_ff),
      .cnt_l      (snap_cnt_l_ff),
      .cnt_r      (snap_cnt_r_ff),
      .min_f      (snap_min_f_ff),
      .min_l      (snap_min_l_ff),
      .min_r      (snap_min_r_ff),
      .rsp        (rsp_word)
   );

endmodule

// ===== hw/rtl/lsa_checker.sv =====
// Port-level checker for lidar_sector_avoidance, bound to the top level.
// Depends on lsa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsa_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        drive_mode,
   input logic signed [1:0] turn_dir,
   input logic [15:0]       front_min_mm,
   input logic [15:0]       left_min_mm,
   input logic [15:0]       right_min_mm
);

   `ASSERT_RUN(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_RUN(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable({drive_mode, turn_dir, front_min_mm, left_min_mm, right_min_mm}))
   `ASSERT_RUN(a_steer_away, rsp_valid && (drive_mode != lsa_pkg::DRIVE_FORWARD) |-> (turn_dir == lsa_pkg::TURN_LEFT) || (turn_dir == lsa_pkg::TURN_RIGHT))
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

endmodule

bind lidar_sector_avoidance lsa_checker u_lsa_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_word.valid),
   .rsp_ready    (rsp_word.ready),
   .drive_mode   (rsp_word.drive_mode),
   .turn_dir     (rsp_word.turn_dir),
   .front_min_mm (rsp_word.front_min_mm),
   .left_min_mm  (rsp_word.left_min_mm),
   .right_min_mm (rsp_word.right_min_mm)
);

// ===== dv/tb_lidar_sector_avoidance.sv =====
// Testbench for lidar_sector_avoidance: drives range words, checks each decision word.
// A directed table, then randomized scans over many register settings, with random stalls.
// Depends on lsa_pkg, lsa_req_if, lsa_rsp_if and the lidar_sector_avoidance RTL.
module tb_lidar_sector_avoidance;

   localparam int SCAN_CAP      = 1024;
   localparam int SETTLE_CYCLES = 6;
   localparam int RESET_ROWS    = 10;
   localparam int DIRECTED_ROWS = 22;
   localparam int N_PHASES      = 8;
   localparam int PHASE_ITEMS   = 10;

   typedef struct packed {
      lsa_pkg::lsa_drive_type drive;
      logic signed [1:0]      turn;
      logic [15:0]            fmin;
      logic [15:0]            lmin;
      logic [15:0]            rmin;
   } scan_result_type;

   typedef struct packed {
      logic [15:0]     range_mm;
      logic            nan;
      logic            is_last;
      logic            typed;
      scan_result_type want;
   } sample_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   lsa_req_if req_if ();
   lsa_rsp_if rsp_if ();

   lidar_sector_avoidance #(.MAX_SAMPLES(SCAN_CAP)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_if),
      .rsp_word  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // register shadow
   logic [15:0] cfg_min_valid = lsa_pkg::RST_MIN_VALID;
   logic [15:0] cfg_max_valid = lsa_pkg::RST_MAX_VALID;
   logic [15:0] cfg_scan_max  = lsa_pkg::RST_SCAN_MAX;
   logic [15:0] cfg_close     = lsa_pkg::RST_CLOSE;
   logic [15:0] cfg_danger    = lsa_pkg::RST_DANGER;
   logic [9:0]  cfg_right_end = lsa_pkg::RST_RIGHT_END;
   logic [9:0]  cfg_front_end = lsa_pkg::RST_FRONT_END;
   logic [15:0] next_cfg [7];

   // scan state
   int                scan_pos;
   longint unsigned   sec_total [3];
   int unsigned       sec_count [3];
   logic [15:0]       sec_min [3];

   scan_result_type pending_decisions [$];
   int error_count;
   int samples_sent;
   int scans_sent;
   int results_seen;
   int settings_used;
   bit quiet_phase;
   bit calm_tail;

   localparam scan_result_type EMPTY_SCAN = '{lsa_pkg::DRIVE_FORWARD, lsa_pkg::TURN_NONE,
      lsa_pkg::SECTOR_MIN_INIT, lsa_pkg::SECTOR_MIN_INIT, lsa_pkg::SECTOR_MIN_INIT};

   // first block at reset settings with typed results, second block with 1-wide right and front sectors
   sample_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'd1000,  1'b0, 1'b1, 1'b1,
        '{lsa_pkg::DRIVE_FORWARD, lsa_pkg::TURN_RIGHT, lsa_pkg::SECTOR_MIN_INIT,
          lsa_pkg::SECTOR_MIN_INIT, 16'd1000}},
      '{16'd1000,  1'b1, 1'b1, 1'b1, EMPTY_SCAN},
      '{16'd0,     1'b0, 1'b1, 1'b1, EMPTY_SCAN},
      '{16'd65535, 1'b0, 1'b1, 1'b1, EMPTY_SCAN},
      '{16'd19,    1'b0, 1'b1, 1'b1, EMPTY_SCAN},
      '{16'd20,    1'b0, 1'b1, 1'b1,
        '{lsa_pkg::DRIVE_FORWARD, lsa_pkg::TURN_NONE, lsa_pkg::SECTOR_MIN_INIT,
          lsa_pkg::SECTOR_MIN_INIT, 16'd20}},
      '{16'd5500,  1'b0, 1'b1, 1'b1,
        '{lsa_pkg::DRIVE_FORWARD, lsa_pkg::TURN_RIGHT, lsa_pkg::SECTOR_MIN_INIT,
          lsa_pkg::SECTOR_MIN_INIT, 16'd5500}},
      '{16'd5501,  1'b0, 1'b1, 1'b1, EMPTY_SCAN},
      '{16'd300,   1'b0, 1'b0, 1'b0, '0},
      '{16'd900,   1'b0, 1'b1, 1'b1,
        '{lsa_pkg::DRIVE_FORWARD, lsa_pkg::TURN_NONE, lsa_pkg::SECTOR_MIN_INIT,
          lsa_pkg::SECTOR_MIN_INIT, 16'd300}},
      '{16'd1000,  1'b0, 1'b0, 1'b0, '0},
      '{16'd500,   1'b0, 1'b0, 1'b0, '0},
      '{16'd2000,  1'b0, 1'b1, 1'b0, '0},
      '{16'd3000,  1'b0, 1'b0, 1'b0, '0},
      '{16'd700,   1'b0, 1'b0, 1'b0, '0},
      '{16'd1000,  1'b0, 1'b1, 1'b0, '0},
      '{16'd900,   1'b0, 1'b0, 1'b0, '0},
      '{16'd900,   1'b0, 1'b0, 1'b0, '0},
      '{16'd900,   1'b0, 1'b1, 1'b0, '0},
      '{16'd700,   1'b0, 1'b0, 1'b0, '0},
      '{16'd1000,  1'b0, 1'b0, 1'b0, '0},
      '{16'd5000,  1'b1, 1'b1, 1'b0, '0}
   };

   function automatic void clear_scan();
      scan_pos = 0;
      for (int s = 0; s < 3; s++) begin
         sec_total[s] = 0;
         sec_count[s] = 0;
         sec_min[s]   = lsa_pkg::SECTOR_MIN_INIT;
      end
   endfunction

   function automatic logic [15:0] sector_floor(lsa_pkg::lsa_sector_type s);
      return (sec_min[s] < cfg_scan_max) ? sec_min[s] : cfg_scan_max;
   endfunction

   function automatic bit avg_under_close(lsa_pkg::lsa_sector_type s);
      longint unsigned n;
      n = (sec_count[s] == 0) ? 64'd1 : 64'(sec_count[s]);
      return sec_total[s] < (64'(cfg_close) * n);
   endfunction

   // folds one range word into the scan; returns 1 with the decision on the last word
   function automatic bit advance_scan(input logic [15:0] rng, input logic nan,
                                       input logic is_last, output scan_result_type res);
      lsa_pkg::lsa_sector_type sec;
      int t;
      res = '0;
      if (scan_pos < SCAN_CAP) begin
         if (!nan && rng >= cfg_min_valid && rng <= cfg_max_valid) begin
            if (scan_pos < cfg_right_end) sec = lsa_pkg::SEC_RIGHT;
            else if (scan_pos < cfg_front_end) sec = lsa_pkg::SEC_FRONT;
            else sec = lsa_pkg::SEC_LEFT;
            sec_total[sec] += rng;
            sec_count[sec]++;
            if (rng < sec_min[sec]) sec_min[sec] = rng;
         end
         scan_pos++;
      end
      if (!is_last) return 1'b0;
      res.fmin = sector_floor(lsa_pkg::SEC_FRONT);
      res.lmin = sector_floor(lsa_pkg::SEC_LEFT);
      res.rmin = sector_floor(lsa_pkg::SEC_RIGHT);
      if (res.fmin < cfg_danger || res.fmin < cfg_close) begin
         res.drive = (res.fmin < cfg_danger) ? lsa_pkg::DRIVE_REVERSE : lsa_pkg::DRIVE_STOP;
         res.turn  = (res.rmin > res.lmin) ? lsa_pkg::TURN_RIGHT : lsa_pkg::TURN_LEFT;
      end else begin
         res.drive = lsa_pkg::DRIVE_FORWARD;
         t = 0;
         if (avg_under_close(lsa_pkg::SEC_LEFT)) t--;
         if (avg_under_close(lsa_pkg::SEC_RIGHT)) t++;
         res.turn = (t < 0) ? lsa_pkg::TURN_RIGHT :
                    (t > 0) ? lsa_pkg::TURN_LEFT : lsa_pkg::TURN_NONE;
      end
      clear_scan();
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d (decision %0d)",
               what, got, want, results_seen);
      error_count++;
   endtask

   always @(posedge clock) begin : decision_check
      scan_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_decisions.size() == 0) begin
            report_mismatch("unexpected decision word", 1, 0);
         end else begin
            want = pending_decisions.pop_front();
            if (rsp_if.drive_mode !== want.drive)
               report_mismatch("drive_mode", int'(rsp_if.drive_mode), int'(want.drive));
            if (rsp_if.turn_dir !== want.turn)
               report_mismatch("turn_dir", int'(rsp_if.turn_dir), int'(want.turn));
            if (rsp_if.front_min_mm !== want.fmin)
               report_mismatch("front_min_mm", int'(rsp_if.front_min_mm), int'(want.fmin));
            if (rsp_if.left_min_mm !== want.lmin)
               report_mismatch("left_min_mm", int'(rsp_if.left_min_mm), int'(want.lmin));
            if (rsp_if.right_min_mm !== want.rmin)
               report_mismatch("right_min_mm", int'(rsp_if.right_min_mm), int'(want.rmin));
            results_seen++;
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet_phase || calm_tail || $urandom_range(0, 7) != 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clock);
         end
      end
   end

   task automatic send_sample(logic [15:0] rng, logic nan, logic is_last, bit typed,
                              scan_result_type want);
      scan_result_type predicted;
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.range_mm     <= rng;
      req_if.not_a_number <= nan;
      req_if.last_sample  <= is_last;
      do @(posedge clock); while (!req_if.ready);
      if (advance_scan(rng, nan, is_last, predicted))
         pending_decisions.push_back(typed ? want : predicted);
      samples_sent++;
      if (is_last) scans_sent++;
   endtask

   task automatic hold_off(int cycles);
      @(negedge clock);
      req_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // sender waits for every pending decision, then lets the pipe settle
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings();
      for (int i = 0; i < 7; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= 3'(lsa_pkg::lsa_csr_type'(i));
         csr_wdata <= next_cfg[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_min_valid = next_cfg[lsa_pkg::CSR_MIN_VALID];
      cfg_max_valid = next_cfg[lsa_pkg::CSR_MAX_VALID];
      cfg_scan_max  = next_cfg[lsa_pkg::CSR_SCAN_MAX];
      cfg_close     = next_cfg[lsa_pkg::CSR_CLOSE];
      cfg_danger    = next_cfg[lsa_pkg::CSR_DANGER];
      cfg_right_end = next_cfg[lsa_pkg::CSR_RIGHT_END][9:0];
      cfg_front_end = next_cfg[lsa_pkg::CSR_FRONT_END][9:0];
      settings_used++;
   endtask

   function automatic void stage_reset_settings();
      next_cfg[lsa_pkg::CSR_MIN_VALID] = lsa_pkg::RST_MIN_VALID;
      next_cfg[lsa_pkg::CSR_MAX_VALID] = lsa_pkg::RST_MAX_VALID;
      next_cfg[lsa_pkg::CSR_SCAN_MAX]  = lsa_pkg::RST_SCAN_MAX;
      next_cfg[lsa_pkg::CSR_CLOSE]     = lsa_pkg::RST_CLOSE;
      next_cfg[lsa_pkg::CSR_DANGER]    = lsa_pkg::RST_DANGER;
      next_cfg[lsa_pkg::CSR_RIGHT_END] = 16'(lsa_pkg::RST_RIGHT_END);
      next_cfg[lsa_pkg::CSR_FRONT_END] = 16'(lsa_pkg::RST_FRONT_END);
   endfunction

   function automatic logic [15:0] pick_reg(int lo, int hi, int top);
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'(top);
         default: return 16'($urandom_range(lo, hi));
      endcase
   endfunction

   // half the ranges cluster around the thresholds in force, the rest are random
   function automatic logic [15:0] pick_range();
      case ($urandom_range(0, 7))
         0: return 16'($urandom_range(0, 65535));
         1: return cfg_min_valid + 16'($urandom_range(0, 2)) - 16'd1;
         2: return cfg_max_valid + 16'($urandom_range(0, 2)) - 16'd1;
         3: return cfg_close + 16'($urandom_range(0, 2)) - 16'd1;
         4: return cfg_danger + 16'($urandom_range(0, 2)) - 16'd1;
         default: return 16'($urandom_range(0, 6000));
      endcase
   endfunction

   task automatic run_scan(int len);
      for (int i = 0; i < len; i++) begin
         if (!quiet_phase && !calm_tail && $urandom_range(0, 4) == 0)
            hold_off($urandom_range(1, 13));
         send_sample(pick_range(), logic'($urandom_range(0, 9) == 0), logic'(i == len - 1),
                     1'b0, '0);
      end
   endtask

   initial begin
      #8_000_000;
      $display("lidar_sector_avoidance test failed");
      $finish;
   end

   initial begin : stimulus
      int phase_items;
      int len;
      req_if.valid        = 1'b0;
      req_if.range_mm     = '0;
      req_if.not_a_number = 1'b0;
      req_if.last_sample  = 1'b0;
      csr_we              = 1'b0;
      csr_index           = 3'(lsa_pkg::CSR_MIN_VALID);
      csr_wdata           = '0;
      error_count         = 0;
      samples_sent        = 0;
      scans_sent          = 0;
      results_seen        = 0;
      settings_used       = 0;
      quiet_phase         = 1'b0;
      calm_tail           = 1'b0;
      clear_scan();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         if (row == RESET_ROWS) begin
            drain();
            stage_reset_settings();
            next_cfg[lsa_pkg::CSR_RIGHT_END] = 16'd1;
            next_cfg[lsa_pkg::CSR_FRONT_END] = 16'd2;
            apply_settings();
         end
         send_sample(directed_rows[row].range_mm, directed_rows[row].nan,
                     directed_rows[row].is_last, directed_rows[row].typed,
                     directed_rows[row].want);
      end

      for (int phase = 0; phase < N_PHASES; phase++) begin
         drain();
         next_cfg[lsa_pkg::CSR_MIN_VALID] = pick_reg(0, 300, 65535);
         next_cfg[lsa_pkg::CSR_MAX_VALID] = pick_reg(1000, 65535, 65535);
         next_cfg[lsa_pkg::CSR_SCAN_MAX]  = pick_reg(500, 65535, 65535);
         next_cfg[lsa_pkg::CSR_CLOSE]     = pick_reg(100, 4000, 65535);
         next_cfg[lsa_pkg::CSR_DANGER]    = pick_reg(50, 2500, 65535);
         next_cfg[lsa_pkg::CSR_RIGHT_END] = pick_reg(0, 12, 1023);
         next_cfg[lsa_pkg::CSR_FRONT_END] = pick_reg(0, 20, 1023);
         case (phase)
            0: next_cfg = '{16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
                            16'd0, 16'd0};
            1: next_cfg = '{16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1023, 16'd1023};
            2: stage_reset_settings();
            3: begin
               next_cfg[lsa_pkg::CSR_RIGHT_END] = 16'd0;
               next_cfg[lsa_pkg::CSR_FRONT_END] = 16'd1023;
            end
            default: ;
         endcase
         apply_settings();
         quiet_phase = ($urandom_range(0, 3) == 0);
         calm_tail   = (phase >= N_PHASES - 3);
         phase_items = 0;
         // an over-long scan runs past the sample index cap
         if (phase == 2) run_scan(SCAN_CAP + 4);
         while (phase_items < PHASE_ITEMS) begin
            len = $urandom_range(1, 24);
            run_scan(len);
            phase_items += len;
         end
      end

      drain();
      $display("%0d range words in %0d scans across %0d register settings",
               samples_sent, scans_sent, settings_used);
      $display("%0d decision words checked, %0d mismatches", results_seen, error_count);
      if (error_count == 0)
         $display("lidar_sector_avoidance test passed");
      else
         $display("lidar_sector_avoidance test failed");
      $finish;
   end

endmodule

// ===== lidar_sector_avoidance.f =====
+incdir+hw/rtl
hw/rtl/lsa_pkg.sv
hw/rtl/lsa_req_if.sv
hw/rtl/lsa_rsp_if.sv
hw/rtl/lsa_decide.sv
hw/rtl/lidar_sector_avoidance.sv
hw/rtl/lsa_checker.sv
dv/tb_lidar_sector_avoidance.sv
